[rtl/pid_lfd_pkg.sv]
// ----------------------------------------------------------------------------
// PID line follower drive: shared package
// Types and constants shared by the drive controller and its MAC unit.
// ----------------------------------------------------------------------------
package pid_lfd_pkg;

    // Control word for the shared multiply-accumulate unit.
    typedef struct packed {
        logic en;
        logic clr;
        logic sh16;
    } mac_op_t;

    localparam int unsigned MAC_A_W   = 33;
    localparam int unsigned MAC_B_W   = 18;
    localparam int unsigned MAC_ACC_W = 64;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SETPOINT   = 3'd0;
    localparam logic [2:0] CFG_P_GAIN     = 3'd1;
    localparam logic [2:0] CFG_I_GAIN     = 3'd2;
    localparam logic [2:0] CFG_D_GAIN     = 3'd3;
    localparam logic [2:0] CFG_BASE_LEFT  = 3'd4;
    localparam logic [2:0] CFG_BASE_RIGHT = 3'd5;
    localparam logic [2:0] CFG_STOP_DIST  = 3'd6;

    // Reset values of the configuration registers.
    localparam logic [11:0] RST_SETPOINT   = 12'd2000;
    localparam logic [15:0] RST_P_GAIN     = 16'd85;
    localparam logic [15:0] RST_I_GAIN     = 16'd8;
    localparam logic [15:0] RST_D_GAIN     = 16'd538;
    localparam logic [15:0] RST_BASE_LEFT  = 16'd27525;
    localparam logic [15:0] RST_BASE_RIGHT = 16'd26214;
    localparam logic [8:0]  RST_STOP_DIST  = 9'd30;

    // Duty threshold (0.15) and floor duty (0.16), Q0.16.
    localparam logic [15:0] DUTY_THRESHOLD = 16'd9830;
    localparam logic [15:0] DUTY_FLOOR     = 16'd10486;

endpackage

[rtl/pid_lfd_mac.sv]
// ----------------------------------------------------------------------------
// PID line follower drive: shared multiply-accumulate unit
// One signed 33x18 multiplier feeding a 64-bit accumulator register.
// ----------------------------------------------------------------------------
module pid_lfd_mac
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  pid_lfd_pkg::mac_op_t                      op,
    input  logic signed [pid_lfd_pkg::MAC_A_W-1:0]    a,
    input  logic signed [pid_lfd_pkg::MAC_B_W-1:0]    b,
    output logic signed [pid_lfd_pkg::MAC_ACC_W-1:0]  acc
);
    import pid_lfd_pkg::*;

    logic signed [MAC_A_W+MAC_B_W-1:0] prod;
    logic signed [MAC_ACC_W-1:0]       prod_ext;
    logic signed [MAC_ACC_W-1:0]       addend;
    logic signed [MAC_ACC_W-1:0]       acc_reg;
    logic signed [MAC_ACC_W-1:0]       acc_next;

    always_comb
    begin
        prod     = a * b;
        prod_ext = MAC_ACC_W'(prod);
        addend   = op.sh16 ? (prod_ext <<< 16) : prod_ext;
        acc_next = op.clr ? addend : (acc_reg + addend);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (op.en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

[rtl/pid_line_follow_drive_unit.sv]
// ----------------------------------------------------------------------------
// PID line follower differential drive unit
// Steps: prepare, P/I/D multiplies, scale, base multiply, reciprocal lo/hi, duty, done;
// a zero control value goes from scale, an obstacle stop from prepare, straight to done.
// Six passes use the single shared MAC; a result held by the sink delays the next request.
// Reset: asynchronous active low; configuration registers return to defaults, PID state
// clears to zero, and the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module pid_line_follow_drive_unit
#(
    parameter int unsigned FULL_SCALE = 550
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // line_position [11:0], obstacle_cm [20:12], zero [23:21]
    input  logic [23:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // left_duty [15:0], right_duty [31:16], control_value [47:32]
    output logic [47:0] m_axis_tdata,
    // obstacle_stop [0]
    output logic        m_axis_tuser,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import pid_lfd_pkg::*;

    localparam int unsigned REC_L = $clog2(FULL_SCALE);
    localparam int unsigned REC_K = 31 + REC_L;
    localparam logic [63:0] REC_M =
        ((64'd1 << REC_K) + 64'(FULL_SCALE) - 64'd1) / 64'(FULL_SCALE);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_SCALE,
        ST_MUL_BASE,
        ST_REC_LO,
        ST_REC_HI,
        ST_DUTY,
        ST_DONE
    } state_t;

    state_t state_reg;

    logic [11:0] setpoint_reg;
    logic [15:0] p_gain_reg;
    logic [15:0] i_gain_reg;
    logic [15:0] d_gain_reg;
    logic [15:0] base_left_reg;
    logic [15:0] base_right_reg;
    logic [8:0]  stop_dist_reg;

    logic signed [31:0] error_sum_reg;
    logic signed [12:0] prev_error_reg;

    logic [11:0]        pos_reg;
    logic [8:0]         dist_reg;
    logic signed [12:0] err_reg;
    logic signed [13:0] deriv_reg;
    logic signed [15:0] value_reg;
    logic [15:0]        mag_reg;
    logic               slow_left_reg;
    logic [30:0]        x_reg;
    logic [15:0]        left_reg;
    logic [15:0]        right_reg;
    logic               stop_reg;

    logic        out_valid_reg;
    logic [47:0] out_data_reg;
    logic        out_user_reg;

    mac_op_t                      mac_op;
    logic signed [MAC_A_W-1:0]    mac_a;
    logic signed [MAC_B_W-1:0]    mac_b;
    logic signed [MAC_ACC_W-1:0]  mac_acc;

    logic signed [12:0] err_next;
    logic signed [13:0] deriv_next;
    logic signed [32:0] sum_wide;
    logic signed [31:0] error_sum_next;
    logic signed [63:0] raw_adj;
    logic signed [63:0] raw_quo;
    logic signed [15:0] value_next;
    logic [16:0]        neg_value;
    logic [15:0]        mag_next;
    logic [63:0]        rec_quo;
    logic [15:0]        slow_base;
    logic signed [33:0] cand;
    logic [15:0]        duty_next;

    pid_lfd_mac u_mac
    (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (mac_op),
        .a     (mac_a),
        .b     (mac_b),
        .acc   (mac_acc)
    );

    always_comb
    begin
        err_next   = $signed({1'b0, pos_reg}) - $signed({1'b0, setpoint_reg});
        deriv_next = 14'(err_next) - 14'(prev_error_reg);
        sum_wide   = 33'(error_sum_reg) + 33'(err_next);
        if (sum_wide[32] != sum_wide[31])
        begin
            error_sum_next = sum_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
        begin
            error_sum_next = sum_wide[31:0];
        end

        raw_adj = mac_acc[63] ? (mac_acc + 64'sd255) : mac_acc;
        raw_quo = raw_adj >>> 8;
        if (raw_quo > 64'sd32767)
        begin
            value_next = 16'sh7FFF;
        end
        else if (raw_quo < -64'sd32768)
        begin
            value_next = 16'sh8000;
        end
        else
        begin
            value_next = raw_quo[15:0];
        end
        neg_value = 17'd0 - {value_next[15], value_next};
        mag_next  = value_next[15] ? neg_value[15:0] : value_next;

        slow_base = slow_left_reg ? base_left_reg : base_right_reg;
        rec_quo   = $unsigned(mac_acc) >> REC_K;
        cand      = $signed({18'd0, slow_base}) - $signed({2'd0, rec_quo[31:0]});
        if (cand < $signed({18'd0, DUTY_THRESHOLD}))
        begin
            duty_next = DUTY_FLOOR;
        end
        else
        begin
            duty_next = cand[15:0];
        end
    end

    always_comb
    begin
        mac_op = '0;
        mac_a  = '0;
        mac_b  = '0;
        unique case (state_reg)
            ST_MUL_P:
            begin
                mac_op = '{en: 1'b1, clr: 1'b1, sh16: 1'b0};
                mac_a  = MAC_A_W'(err_reg);
                mac_b  = $signed({2'd0, p_gain_reg});
            end
            ST_MUL_I:
            begin
                mac_op = '{en: 1'b1, clr: 1'b0, sh16: 1'b0};
                mac_a  = MAC_A_W'(error_sum_reg);
                mac_b  = $signed({2'd0, i_gain_reg});
            end
            ST_MUL_D:
            begin
                mac_op = '{en: 1'b1, clr: 1'b0, sh16: 1'b0};
                mac_a  = MAC_A_W'(deriv_reg);
                mac_b  = $signed({2'd0, d_gain_reg});
            end
            ST_MUL_BASE:
            begin
                mac_op = '{en: 1'b1, clr: 1'b1, sh16: 1'b0};
                mac_a  = $signed({17'd0, mag_reg});
                mac_b  = $signed({2'd0, slow_base});
            end
            ST_REC_LO:
            begin
                mac_op = '{en: 1'b1, clr: 1'b1, sh16: 1'b0};
                mac_a  = $signed({2'd0, mac_acc[30:0]});
                mac_b  = $signed({2'd0, REC_M[15:0]});
            end
            ST_REC_HI:
            begin
                mac_op = '{en: 1'b1, clr: 1'b0, sh16: 1'b1};
                mac_a  = $signed({2'd0, x_reg});
                mac_b  = $signed({2'd0, REC_M[31:16]});
            end
            default:
            begin
                mac_op = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            setpoint_reg   <= RST_SETPOINT;
            p_gain_reg     <= RST_P_GAIN;
            i_gain_reg     <= RST_I_GAIN;
            d_gain_reg     <= RST_D_GAIN;
            base_left_reg  <= RST_BASE_LEFT;
            base_right_reg <= RST_BASE_RIGHT;
            stop_dist_reg  <= RST_STOP_DIST;
            error_sum_reg  <= '0;
            prev_error_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_SETPOINT:   setpoint_reg   <= cfg_data[11:0];
                    CFG_P_GAIN:     p_gain_reg     <= cfg_data;
                    CFG_I_GAIN:     i_gain_reg     <= cfg_data;
                    CFG_D_GAIN:     d_gain_reg     <= cfg_data;
                    CFG_BASE_LEFT:  base_left_reg  <= cfg_data;
                    CFG_BASE_RIGHT: base_right_reg <= cfg_data;
                    CFG_STOP_DIST:  stop_dist_reg  <= cfg_data[8:0];
                    default:        ;
                endcase
            end

            if (out_valid_reg && m_axis_tready && state_reg != ST_DONE)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        pos_reg   <= s_axis_tdata[11:0];
                        dist_reg  <= s_axis_tdata[20:12];
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP:
                begin
                    if (dist_reg <= stop_dist_reg)
                    begin
                        left_reg  <= '0;
                        right_reg <= '0;
                        stop_reg  <= 1'b1;
                        value_reg <= '0;
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        left_reg       <= base_left_reg;
                        right_reg      <= base_right_reg;
                        stop_reg       <= 1'b0;
                        err_reg        <= err_next;
                        deriv_reg      <= deriv_next;
                        error_sum_reg  <= error_sum_next;
                        prev_error_reg <= err_next;
                        state_reg      <= ST_MUL_P;
                    end
                end
                ST_MUL_P:
                begin
                    state_reg <= ST_MUL_I;
                end
                ST_MUL_I:
                begin
                    state_reg <= ST_MUL_D;
                end
                ST_MUL_D:
                begin
                    state_reg <= ST_SCALE;
                end
                ST_SCALE:
                begin
                    value_reg     <= value_next;
                    mag_reg       <= mag_next;
                    slow_left_reg <= value_next[15];
                    if (value_next == 16'sd0)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= ST_MUL_BASE;
                    end
                end
                ST_MUL_BASE:
                begin
                    state_reg <= ST_REC_LO;
                end
                ST_REC_LO:
                begin
                    x_reg     <= mac_acc[30:0];
                    state_reg <= ST_REC_HI;
                end
                ST_REC_HI:
                begin
                    state_reg <= ST_DUTY;
                end
                ST_DUTY:
                begin
                    if (slow_left_reg)
                    begin
                        left_reg <= duty_next;
                    end
                    else
                    begin
                        right_reg <= duty_next;
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {value_reg, right_reg, left_reg};
                        out_user_reg  <= stop_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule
